/* hdl/vfl_pkg.sv */
// ----------------------------------------------------------------------------
// vfl_pkg
// Shared types, constants and corner functions for the voxel face AO and
// smooth light pipeline.
// ----------------------------------------------------------------------------
package vfl_pkg;

   localparam int unsigned NUM_CORNERS  = 4;
   localparam int unsigned SAMPLE_W     = 4;
   localparam int unsigned SAMPLES_W    = 36;
   localparam int unsigned MASK_W       = 9;
   localparam int unsigned SUM_W        = 6;
   localparam int unsigned CNT_W        = 3;
   localparam int unsigned AO_W         = 8;
   localparam int unsigned LIGHT_W      = 16;
   localparam logic [3:0]  CENTER_IDX   = 4'd4;
   localparam logic [15:0] UNIFORM_SPREAD = 16'h1111;
   localparam logic [6:0]  RECIP_THIRD  = 7'd43;
   localparam logic [1:0]  AO_FULL      = 2'd3;

   // side0, diagonal, side1 per corner
   localparam logic [3:0] CORNER_IDX [NUM_CORNERS][3] = '{
      '{4'd1, 4'd0, 4'd3},
      '{4'd3, 4'd6, 4'd7},
      '{4'd7, 4'd8, 4'd5},
      '{4'd5, 4'd2, 4'd1}
   };

   typedef struct packed {
      logic [SUM_W-1:0] sum;
      logic [CNT_W-1:0] cnt;
   } corner_acc_type;

   typedef struct packed {
      logic                                emitting;
      logic [SAMPLE_W-1:0]                 emission;
      logic [AO_W-1:0]                     ao;
      logic [NUM_CORNERS-1:0][CNT_W-1:0]   cnt;
      logic [NUM_CORNERS-1:0][SUM_W-1:0]   blk_sum;
      logic [NUM_CORNERS-1:0][SUM_W-1:0]   sky_sum;
   } gather_type;

   typedef struct packed {
      logic [AO_W-1:0]    ao;
      logic [LIGHT_W-1:0] blk;
      logic [LIGHT_W-1:0] sky;
   } result_type;

   function automatic logic [SAMPLE_W-1:0] sample_at(input logic [SAMPLES_W-1:0] samples,
                                                     input logic [3:0] idx);
      return samples[SAMPLE_W*idx +: SAMPLE_W];
   endfunction

   function automatic logic [1:0] corner_ao(input logic [MASK_W-1:0] mask,
                                            input logic [1:0] k);
      logic s0;
      logic d;
      logic s1;
      s0 = mask[CORNER_IDX[k][0]];
      d  = mask[CORNER_IDX[k][1]];
      s1 = mask[CORNER_IDX[k][2]];
      if (s0 && s1) begin
         return AO_FULL;
      end
      return 2'({1'b0, s0} + {1'b0, d} + {1'b0, s1});
   endfunction

   function automatic corner_acc_type corner_acc(input logic [SAMPLES_W-1:0] samples,
                                                 input logic [MASK_W-1:0] mask,
                                                 input logic [1:0] k);
      corner_acc_type r;
      logic s0;
      logic d;
      logic s1;
      s0 = mask[CORNER_IDX[k][0]];
      d  = mask[CORNER_IDX[k][1]];
      s1 = mask[CORNER_IDX[k][2]];
      r.sum = {2'b00, sample_at(samples, CENTER_IDX)};
      r.cnt = 3'd1;
      if (!s0) begin
         r.sum = r.sum + {2'b00, sample_at(samples, CORNER_IDX[k][0])};
         r.cnt = r.cnt + 3'd1;
      end
      if (!s1) begin
         r.sum = r.sum + {2'b00, sample_at(samples, CORNER_IDX[k][2])};
         r.cnt = r.cnt + 3'd1;
      end
      if (!d && !(s0 && s1)) begin
         r.sum = r.sum + {2'b00, sample_at(samples, CORNER_IDX[k][1])};
         r.cnt = r.cnt + 3'd1;
      end
      return r;
   endfunction

   // rounded (sum + n/2) / n for n in 1..4; divide by 3 as *43 >> 7
   function automatic logic [SAMPLE_W-1:0] round_avg(input logic [SUM_W-1:0] sum,
                                                     input logic [CNT_W-1:0] cnt);
      logic [SUM_W:0]   rnd;
      logic [12:0]      prod;
      logic [SAMPLE_W-1:0] q;
      rnd  = '0;
      prod = '0;
      unique case (cnt)
         3'd1: begin
            q = sum[3:0];
         end
         3'd2: begin
            rnd = {1'b0, sum} + 7'd1;
            q   = rnd[4:1];
         end
         3'd3: begin
            rnd  = {1'b0, sum} + 7'd1;
            prod = {6'd0, rnd} * {6'd0, RECIP_THIRD};
            q    = prod[10:7];
         end
         3'd4: begin
            rnd = {1'b0, sum} + 7'd2;
            q   = rnd[5:2];
         end
         default: begin
            q = '0;
         end
      endcase
      return q;
   endfunction

endpackage

/* hdl/vfl_req_if.sv */
// ----------------------------------------------------------------------------
// vfl_req_if
// Face request channel: valid/ready with one face word.
// ----------------------------------------------------------------------------
interface vfl_req_if;
   logic                           valid;
   logic                           ready;
   logic [vfl_pkg::MASK_W-1:0]     occupancy_mask;
   logic [vfl_pkg::SAMPLES_W-1:0]  block_light_samples;
   logic [vfl_pkg::SAMPLES_W-1:0]  sky_light_samples;
   logic [vfl_pkg::SAMPLE_W-1:0]   emission_level;

   modport source (output valid, occupancy_mask, block_light_samples, sky_light_samples,
                   emission_level, input ready);
   modport sink   (input valid, occupancy_mask, block_light_samples, sky_light_samples,
                   emission_level, output ready);
endinterface

/* hdl/vfl_rsp_if.sv */
// ----------------------------------------------------------------------------
// vfl_rsp_if
// Result channel: valid/ready with one corner AO and light word.
// ----------------------------------------------------------------------------
interface vfl_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [vfl_pkg::AO_W-1:0]      ao_corners;
   logic [vfl_pkg::LIGHT_W-1:0]   block_light_corners;
   logic [vfl_pkg::LIGHT_W-1:0]   sky_light_corners;

   modport source (output valid, ao_corners, block_light_corners, sky_light_corners,
                   input ready);
   modport sink   (input valid, ao_corners, block_light_corners, sky_light_corners,
                   output ready);
endinterface

/* hdl/vfl_gather.sv */
// ----------------------------------------------------------------------------
// vfl_gather
// Stage 1: per-corner AO and masked sample sums and counts.
// ----------------------------------------------------------------------------
module vfl_gather (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   output logic                           in_ready,
   input  logic [vfl_pkg::MASK_W-1:0]     in_mask,
   input  logic [vfl_pkg::SAMPLES_W-1:0]  in_blk,
   input  logic [vfl_pkg::SAMPLES_W-1:0]  in_sky,
   input  logic [vfl_pkg::SAMPLE_W-1:0]   in_emission,
   output logic                           out_valid,
   input  logic                           out_ready,
   output vfl_pkg::gather_type            out_data
);

   logic                 valid_ff;
   logic                 valid_in;
   vfl_pkg::gather_type  data_ff;
   vfl_pkg::gather_type  data_in;
   logic                 advance;

   assign in_ready = !valid_ff || out_ready;
   assign advance  = in_valid && in_ready;

   always_comb begin
      vfl_pkg::corner_acc_type ba;
      vfl_pkg::corner_acc_type sa;
      data_in          = '0;
      data_in.emitting = (in_emission != '0);
      data_in.emission = in_emission;
      for (int k = 0; k < vfl_pkg::NUM_CORNERS; k++) begin
         ba = vfl_pkg::corner_acc(in_blk, in_mask, 2'(k));
         sa = vfl_pkg::corner_acc(in_sky, in_mask, 2'(k));
         data_in.cnt[k]     = ba.cnt;
         data_in.blk_sum[k] = ba.sum;
         data_in.sky_sum[k] = sa.sum;
         if (!data_in.emitting) begin
            data_in.ao[2*k +: 2] = vfl_pkg::corner_ao(in_mask, 2'(k));
         end
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (in_ready) begin
         valid_in = in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (data_ff.cnt[0] != '0 && data_ff.cnt[0] <= 3'd4 &&
                    data_ff.cnt[1] != '0 && data_ff.cnt[1] <= 3'd4 &&
                    data_ff.cnt[2] != '0 && data_ff.cnt[2] <= 3'd4 &&
                    data_ff.cnt[3] != '0 && data_ff.cnt[3] <= 3'd4))
      else $error("corner count out of range");

   a_emit_no_ao: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && data_ff.emitting) |-> (data_ff.ao == '0))
      else $error("emitting face carries AO");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !out_ready) |=> (valid_ff && $stable(data_ff)))
      else $error("stage 1 word changed while stalled");

endmodule

/* hdl/vfl_average.sv */
// ----------------------------------------------------------------------------
// vfl_average
// Stage 2: rounded corner averages and emission override of block light.
// ----------------------------------------------------------------------------
module vfl_average (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  vfl_pkg::gather_type  in_data,
   output logic                 out_valid,
   input  logic                 out_ready,
   output vfl_pkg::result_type  out_data
);

   logic                 valid_ff;
   logic                 valid_in;
   vfl_pkg::result_type  data_ff;
   vfl_pkg::result_type  data_in;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      data_in    = '0;
      data_in.ao = in_data.ao;
      for (int k = 0; k < vfl_pkg::NUM_CORNERS; k++) begin
         data_in.blk[4*k +: 4] = vfl_pkg::round_avg(in_data.blk_sum[k], in_data.cnt[k]);
         data_in.sky[4*k +: 4] = vfl_pkg::round_avg(in_data.sky_sum[k], in_data.cnt[k]);
      end
      if (in_data.emitting) begin
         data_in.blk = 16'({12'd0, in_data.emission} * vfl_pkg::UNIFORM_SPREAD);
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (in_ready) begin
         valid_in = in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

/* hdl/voxel_face_ao_and_smooth_light.sv */
// ----------------------------------------------------------------------------
// voxel_face_ao_and_smooth_light
// An accepted req word passes the gather, average and output registers.
// Throughput: one face word per cycle, set by the three-stage pipeline
// (gather sums, rounded average, output register); a stall holds full stages.
// Reset clears only the stage valid bits; the data registers are not reset.
// ----------------------------------------------------------------------------
module voxel_face_ao_and_smooth_light (
   input  logic       clock,
   input  logic       reset,
   vfl_req_if.sink    req_chan,
   vfl_rsp_if.source  rsp_chan
);

   logic                 g_valid;
   logic                 g_ready;
   vfl_pkg::gather_type  g_data;
   logic                 a_valid;
   logic                 a_ready;
   vfl_pkg::result_type  a_data;
   logic                 out_valid_ff;
   logic                 out_valid_in;
   vfl_pkg::result_type  out_data_ff;

   vfl_gather u_gather (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_chan.valid),
      .in_ready    (req_chan.ready),
      .in_mask     (req_chan.occupancy_mask),
      .in_blk      (req_chan.block_light_samples),
      .in_sky      (req_chan.sky_light_samples),
      .in_emission (req_chan.emission_level),
      .out_valid   (g_valid),
      .out_ready   (g_ready),
      .out_data    (g_data)
   );

   vfl_average u_average (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (g_valid),
      .in_ready  (g_ready),
      .in_data   (g_data),
      .out_valid (a_valid),
      .out_ready (a_ready),
      .out_data  (a_data)
   );

   assign a_ready = !out_valid_ff || rsp_chan.ready;

   always_comb begin
      out_valid_in = out_valid_ff;
      if (a_ready) begin
         out_valid_in = a_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (a_valid && a_ready) begin
         out_data_ff <= a_data;
      end
   end

   assign rsp_chan.valid               = out_valid_ff;
   assign rsp_chan.ao_corners          = out_data_ff.ao;
   assign rsp_chan.block_light_corners = out_data_ff.blk;
   assign rsp_chan.sky_light_corners   = out_data_ff.sky;

   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_chan.ready) |=> (out_valid_ff && $stable(out_data_ff)))
      else $error("output word changed while stalled");

   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      (a_valid && !a_ready) |=> a_valid)
      else $error("stage 2 word dropped under stall");

   a_fill: assert property (@(posedge clock) disable iff (reset)
      (a_valid && a_ready) |=> out_valid_ff)
      else $error("output register missed a word");

endmodule
